// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define FFBA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ffba assertion failed");

// clocked assertion, checked at every edge
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ffba assertion failed");

`endif

// ===== rtl/core/ffba_pkg.sv =====
// types and codes of the first-fit block allocator
// no dependencies
package ffba_pkg;

  // position width covers the largest table size
  localparam int PTR_W = 11;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESIZE  = 2'd2;
  localparam logic [1:0] OP_RSVD    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOERR       = 3'd1,
    ST_EXHAUSTED   = 3'd2,
    ST_NOT_BLOCK   = 3'd3,
    ST_DOUBLE_FREE = 3'd4,
    ST_TABLE_FULL  = 3'd5
  } ffba_status_t;

  typedef struct packed {
    logic [20:0] start;
    logic [20:0] size;
    logic        free;
  } ffba_entry_t;

  // command broadcast to every cell of the table
  typedef struct packed {
    logic             ins;
    logic [PTR_W-1:0] ins_pos;
    ffba_entry_t      ins_data;
    logic             rem;
    logic [PTR_W-1:0] rem_pos;
    logic             wr;
    logic [PTR_W-1:0] wr_pos;
    logic             wr_size_en;
    logic [20:0]      wr_size;
    logic             wr_free_en;
    logic             wr_free;
    logic [PTR_W-1:0] rd_pos;
  } ffba_cmd_t;

endpackage

// ===== rtl/core/ffba_cell.sv =====
// one table entry of the allocator, shifts with its neighbors
// depends on ffba_pkg
module ffba_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  ffba_pkg::ffba_cmd_t   cmd,
  input  ffba_pkg::ffba_entry_t left,
  input  ffba_pkg::ffba_entry_t right,
  output ffba_pkg::ffba_entry_t rd_q,
  output ffba_pkg::ffba_entry_t q
);
  import ffba_pkg::*;

  localparam logic [PTR_W-1:0] MY = PTR_W'(IDX);

  ffba_entry_t ent_r;
  ffba_entry_t ent_nxt;

  // insert shifts up, remove shifts down, then a field write
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins && cmd.ins_pos == MY) begin
      ent_nxt = cmd.ins_data;
    end else if (cmd.ins && MY > cmd.ins_pos) begin
      ent_nxt = left;
    end else if (cmd.rem && MY >= cmd.rem_pos) begin
      ent_nxt = right;
    end
    if (cmd.wr && cmd.wr_pos == MY) begin
      if (cmd.wr_size_en) begin
        ent_nxt.size = cmd.wr_size;
      end
      if (cmd.wr_free_en) begin
        ent_nxt.free = cmd.wr_free;
      end
    end
  end

  // drive the read bus only when addressed
  assign rd_q = (cmd.rd_pos == MY) ? ent_r : '0;

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // entry as seen by the neighbors for shifting
  assign q = ent_r;

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// first-fit heap allocator with coalescing over a row of table cells
// depends on ffba_pkg and ffba_cell
//
// One transaction is taken at a time. Each one passes the decode state and the
// result state plus its table walks: a lookup walks up to block_count entries,
// an allocate scan walks up to block_count entries, a relocating resize looks
// its old block up a second time, and a release ends in a merge pass over the
// live entries. The result waits in the result state while out_stall holds the
// output register. The walks run at one entry per cycle through the single read
// bus of the cell row; inserts and removals shift the whole row at once.
// ALIGN_BYTES must be a power of two.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS      = 64,
  parameter int HEAP_BYTES      = 1048576,
  parameter int ALIGN_BYTES     = 16,
  parameter int HEADER_BYTES    = 32,
  parameter int MIN_SPLIT_BYTES = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [20:0] in_request_bytes,
  input  logic [20:0] in_payload_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_result_offset,
  output logic [2:0]  out_status,
  output logic [20:0] out_copy_bytes,
  output logic [20:0] out_copy_from,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data
);
  import ffba_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0]  MAXC     = CW'(MAX_BLOCKS);
  localparam logic [24:0]    HEAP_LIM = 25'(HEAP_BYTES);
  localparam logic [21:0]    AMASK    = 22'(ALIGN_BYTES - 1);
  localparam logic [21:0]    HDR22    = 22'(HEADER_BYTES);
  localparam logic [22:0]    MINS23   = 23'(MIN_SPLIT_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FIND, S_RZ_NEXT, S_AL_SCAN, S_AL_GROW,
    S_SPLIT, S_MG_LOAD, S_MG_STEP, S_DONE
  } state_t;

  state_t       state_r, state_nxt;
  logic [1:0]   op_r, op_nxt;
  logic [20:0]  req_r, req_nxt;
  logic [20:0]  pay_r, pay_nxt;
  logic [21:0]  want_r, want_nxt;
  logic [20:0]  heap_limit_r, heap_limit_nxt;
  logic [20:0]  heap_end_r, heap_end_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] sp_idx_r, sp_idx_nxt;
  logic [20:0]  sp_start_r, sp_start_nxt;
  logic [21:0]  sp_have_r, sp_have_nxt;
  logic [20:0]  orig_size_r, orig_size_nxt;
  logic [20:0]  psize_r, psize_nxt;
  logic         pfree_r, pfree_nxt;
  logic         rs_mode_r, rs_mode_nxt;
  logic         reloc_r, reloc_nxt;
  logic [20:0]  res_r, res_nxt;
  ffba_status_t st_r, st_nxt;
  logic [20:0]  cb_r, cb_nxt;
  logic [20:0]  cf_r, cf_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [20:0]  out_res_r, out_res_nxt;
  logic [2:0]   out_st_r, out_st_nxt;
  logic [20:0]  out_cb_r, out_cb_nxt;
  logic [20:0]  out_cf_r, out_cf_nxt;

  ffba_cmd_t    cmd;
  ffba_entry_t  rd;
  ffba_entry_t  cell_rd [MAX_BLOCKS];
  ffba_entry_t  cell_q  [MAX_BLOCKS];

  // cell row; each cell sees its neighbors' entries for shifting
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffba_entry_t lft;
    ffba_entry_t rgt;
    if (k == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = cell_q[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_mid_r
      assign rgt = cell_q[k+1];
    end
    ffba_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (lft),
      .right (rgt),
      .rd_q  (cell_rd[k]),
      .q     (cell_q[k])
    );
  end

  // read bus: only the addressed cell drives non-zero data
  always_comb begin
    rd = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      rd = rd | cell_rd[k];
    end
  end

  // datapath helpers
  logic [24:0] lim;
  logic [24:0] grow_end;
  logic        pay_hit;
  logic        rd_fits;
  logic [21:0] combined;
  logic        do_split;
  logic        out_take;

  assign lim      = ({4'b0, heap_limit_r} > HEAP_LIM) ? HEAP_LIM : {4'b0, heap_limit_r};
  assign grow_end = 25'(heap_end_r) + 25'(HDR22) + 25'(want_r);
  assign pay_hit  = (22'(rd.start) + HDR22) == 22'(pay_r);
  assign rd_fits  = 22'(rd.size) >= want_r;
  assign combined = 22'(orig_size_r) + HDR22 + 22'(rd.size);
  assign do_split = (23'(sp_have_r) >= 23'(want_r) + MINS23) && (count_r < MAXC);
  assign out_take = out_valid_r && !out_stall;

  // control sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    pay_nxt        = pay_r;
    want_nxt       = want_r;
    heap_limit_nxt = cfg_wr_en ? cfg_wr_data : heap_limit_r;
    heap_end_nxt   = heap_end_r;
    count_nxt      = count_r;
    i_nxt          = i_r;
    sp_idx_nxt     = sp_idx_r;
    sp_start_nxt   = sp_start_r;
    sp_have_nxt    = sp_have_r;
    orig_size_nxt  = orig_size_r;
    psize_nxt      = psize_r;
    pfree_nxt      = pfree_r;
    rs_mode_nxt    = rs_mode_r;
    reloc_nxt      = reloc_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    cb_nxt         = cb_r;
    cf_nxt         = cf_r;
    out_valid_nxt  = out_take ? 1'b0 : out_valid_r;
    out_res_nxt    = out_res_r;
    out_st_nxt     = out_st_r;
    out_cb_nxt     = out_cb_r;
    out_cf_nxt     = out_cf_r;
    cmd            = '0;
    cmd.rd_pos     = PTR_W'(i_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          req_nxt   = in_request_bytes;
          pay_nxt   = in_payload_offset;
          want_nxt  = (22'(in_request_bytes) + AMASK) & ~AMASK;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_nxt   = '0;
        st_nxt    = ST_NOERR;
        cb_nxt    = '0;
        cf_nxt    = '0;
        reloc_nxt = 1'b0;
        i_nxt     = '0;
        state_nxt = S_DONE;
        if (op_r == OP_ALLOC || (op_r == OP_RESIZE && pay_r == '0)) begin
          if (req_r != '0) begin
            state_nxt = S_AL_SCAN;
          end
        end else if (op_r == OP_RELEASE) begin
          if (pay_r != '0) begin
            rs_mode_nxt = 1'b0;
            state_nxt   = S_FIND;
          end
        end else if (op_r == OP_RESIZE) begin
          rs_mode_nxt = (req_r != '0);
          state_nxt   = S_FIND;
        end
      end

      // walk the table for the block whose payload matches
      S_FIND: begin
        if (i_r == count_r) begin
          st_nxt    = ST_NOT_BLOCK;
          state_nxt = S_DONE;
        end else if (pay_hit) begin
          sp_idx_nxt    = i_r;
          sp_start_nxt  = rd.start;
          sp_have_nxt   = 22'(rd.size);
          orig_size_nxt = rd.size;
          if (rd.free) begin
            st_nxt    = ST_DOUBLE_FREE;
            state_nxt = S_DONE;
          end else if (!rs_mode_r) begin
            cmd.wr         = 1'b1;
            cmd.wr_pos     = PTR_W'(i_r);
            cmd.wr_free_en = 1'b1;
            cmd.wr_free    = 1'b1;
            i_nxt          = '0;
            state_nxt      = S_MG_LOAD;
          end else if (rd_fits) begin
            state_nxt = S_SPLIT;
          end else if (CW'(i_r + 1'b1) < count_r) begin
            i_nxt     = CW'(i_r + 1'b1);
            state_nxt = S_RZ_NEXT;
          end else begin
            reloc_nxt = 1'b1;
            i_nxt     = '0;
            state_nxt = S_AL_SCAN;
          end
        end else begin
          i_nxt = CW'(i_r + 1'b1);
        end
      end

      // resize: try to absorb the following free block
      S_RZ_NEXT: begin
        if (rd.free && combined >= want_r) begin
          cmd.rem     = 1'b1;
          cmd.rem_pos = PTR_W'(i_r);
          count_nxt   = CW'(count_r - 1'b1);
          sp_have_nxt = combined;
          state_nxt   = S_SPLIT;
        end else begin
          reloc_nxt = 1'b1;
          i_nxt     = '0;
          state_nxt = S_AL_SCAN;
        end
      end

      // first-fit scan over the free blocks
      S_AL_SCAN: begin
        if (i_r == count_r) begin
          state_nxt = S_AL_GROW;
        end else if (rd.free && rd_fits) begin
          sp_idx_nxt   = i_r;
          sp_start_nxt = rd.start;
          sp_have_nxt  = 22'(rd.size);
          state_nxt    = S_SPLIT;
        end else begin
          i_nxt = CW'(i_r + 1'b1);
        end
      end

      // append a block at the heap end
      S_AL_GROW: begin
        if (grow_end > lim) begin
          st_nxt    = ST_EXHAUSTED;
          state_nxt = S_DONE;
        end else if (count_r >= MAXC) begin
          st_nxt    = ST_TABLE_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.ins            = 1'b1;
          cmd.ins_pos        = PTR_W'(count_r);
          cmd.ins_data.start = heap_end_r;
          cmd.ins_data.size  = want_r[20:0];
          cmd.ins_data.free  = 1'b0;
          count_nxt          = CW'(count_r + 1'b1);
          heap_end_nxt       = grow_end[20:0];
          res_nxt            = 21'(22'(heap_end_r) + HDR22);
          if (reloc_r) begin
            rs_mode_nxt = 1'b0;
            i_nxt       = '0;
            state_nxt   = S_FIND;
          end else begin
            st_nxt    = ST_OK;
            state_nxt = S_DONE;
          end
        end
      end

      // take the block, splitting off the remainder when large enough and the table has room
      S_SPLIT: begin
        cmd.wr         = 1'b1;
        cmd.wr_pos     = PTR_W'(sp_idx_r);
        cmd.wr_size_en = 1'b1;
        cmd.wr_size    = do_split ? want_r[20:0] : sp_have_r[20:0];
        cmd.wr_free_en = 1'b1;
        cmd.wr_free    = 1'b0;
        if (do_split) begin
          cmd.ins            = 1'b1;
          cmd.ins_pos        = PTR_W'(CW'(sp_idx_r + 1'b1));
          cmd.ins_data.start = 21'(22'(sp_start_r) + HDR22 + want_r);
          cmd.ins_data.size  = 21'(sp_have_r - want_r - HDR22);
          cmd.ins_data.free  = 1'b1;
          count_nxt          = CW'(count_r + 1'b1);
        end
        res_nxt = 21'(22'(sp_start_r) + HDR22);
        if (reloc_r) begin
          rs_mode_nxt = 1'b0;
          i_nxt       = '0;
          state_nxt   = S_FIND;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end
      end

      // merge pass: hold the previous entry, compare with the next
      S_MG_LOAD: begin
        psize_nxt = rd.size;
        pfree_nxt = rd.free;
        i_nxt     = CW'(1);
        state_nxt = S_MG_STEP;
      end

      S_MG_STEP: begin
        if (i_r >= count_r) begin
          st_nxt = ST_OK;
          if (reloc_r) begin
            cb_nxt = orig_size_r;
            cf_nxt = pay_r;
          end else begin
            res_nxt = '0;
          end
          state_nxt = S_DONE;
        end else if (pfree_r && rd.free) begin
          cmd.wr         = 1'b1;
          cmd.wr_pos     = PTR_W'(CW'(i_r - 1'b1));
          cmd.wr_size_en = 1'b1;
          cmd.wr_size    = 21'(22'(psize_r) + HDR22 + 22'(rd.size));
          cmd.rem        = 1'b1;
          cmd.rem_pos    = PTR_W'(i_r);
          count_nxt      = CW'(count_r - 1'b1);
          psize_nxt      = 21'(22'(psize_r) + HDR22 + 22'(rd.size));
        end else begin
          psize_nxt = rd.size;
          pfree_nxt = rd.free;
          i_nxt     = CW'(i_r + 1'b1);
        end
      end

      // hand the transaction to the output register
      S_DONE: begin
        if (!out_valid_r || out_take) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_st_nxt    = st_r;
          out_cb_nxt    = cb_r;
          out_cf_nxt    = cf_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      heap_end_r   <= '0;
      heap_limit_r <= 21'h100000;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      heap_end_r   <= heap_end_nxt;
      heap_limit_r <= heap_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    req_r       <= req_nxt;
    pay_r       <= pay_nxt;
    want_r      <= want_nxt;
    i_r         <= i_nxt;
    sp_idx_r    <= sp_idx_nxt;
    sp_start_r  <= sp_start_nxt;
    sp_have_r   <= sp_have_nxt;
    orig_size_r <= orig_size_nxt;
    psize_r     <= psize_nxt;
    pfree_r     <= pfree_nxt;
    rs_mode_r   <= rs_mode_nxt;
    reloc_r     <= reloc_nxt;
    res_r       <= res_nxt;
    st_r        <= st_nxt;
    cb_r        <= cb_nxt;
    cf_r        <= cf_nxt;
    out_res_r   <= out_res_nxt;
    out_st_r    <= out_st_nxt;
    out_cb_r    <= out_cb_nxt;
    out_cf_r    <= out_cf_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_offset = out_res_r;
  assign out_status        = out_st_r;
  assign out_copy_bytes    = out_cb_r;
  assign out_copy_from     = out_cf_r;

endmodule

// ===== rtl/core/ffba_checker.sv =====
// port-level checks of the first-fit block allocator, bound to the top level
// depends on ffba_pkg and assert_macros.svh
`include "assert_macros.svh"

module ffba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] out_result_offset,
  input logic [2:0]  out_status,
  input logic [20:0] out_copy_bytes,
  input logic [20:0] out_copy_from
);
  import ffba_pkg::*;

  // a stalled result holds
  `FFBA_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_result_offset) && $stable(out_status))
  // one transaction at a time: busy right after an accept
  `FFBA_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
  // an error never grants a block or a copy
  `FFBA_ASSERT(a_err_no_block, clk, rst_n, out_valid && out_status != ST_OK |-> out_result_offset == 21'd0 && out_copy_bytes == 21'd0)
  // a copy comes only with a relocation to a new block
  `FFBA_ASSERT(a_copy_reloc, clk, rst_n, out_valid && out_copy_bytes != 21'd0 |-> out_copy_from != 21'd0 && out_result_offset != 21'd0 && out_status == ST_OK)
  // status stays within its codes
  `FFBA_ASSERT_ALWAYS(a_status_range, clk, !(rst_n && out_valid) || out_status <= ST_TABLE_FULL)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
